/* rtl/ucs_pkg.sv */
// Shared constants for the unit cube to simplex map.
package ucs_pkg;
    localparam int SPLIT_W       = 5;
    localparam int CUBE_W        = 18;
    localparam int SENS_W        = 17;
    localparam int COORD_W       = 4;
    localparam int DEF_MAX_SPLIT = 16;
    localparam int DEF_FRAC_BITS = 16;
    localparam logic [SPLIT_W-1:0] SPLIT_RESET = 5'd4;
    localparam logic REG_X_SPLIT = 1'b0;
    localparam logic REG_Y_SPLIT = 1'b1;
endpackage

/* rtl/ucs_sermul.sv */
// Bit-serial fixed-point multiplier: result = (a * b) >> (W-1).
module ucs_sermul #(
    parameter int W = 17
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic         done,
    output logic [W-1:0] result
);
    localparam int CW = (W > 1) ? $clog2(W) : 1;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  hi_reg, hi_next;
    logic [W-1:0]  lo_reg, lo_next;
    logic [W:0]    sum;

    always_comb
    begin
        sum       = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = a;
            hi_next   = '0;
            lo_next   = b;
        end
        else if (busy_reg)
        begin
            hi_next  = sum[W:1];
            lo_next  = {sum[0], lo_reg[W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(W-1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign done   = done_reg;
    assign result = {hi_reg[W-2:0], lo_reg[W-1]};
endmodule

/* rtl/unit_cube_to_simplex_map.sv */
// Unit cube to simplex map: stick-breaking subpixel sensitivities from cube coordinates.
// One input item is worked at a time. The k-th root is found by a binary search of
// FRAC_BITS+1 steps; each step raises the candidate to the k-th power with up to k
// products on a bit-serial multiplier, stopping early once the power falls to the
// target, with k the number of subpixels still to come. No search is run for c = 1.0,
// errors or the 1x1 case.
// A finished result waits in the output register while the next item is taken.
module unit_cube_to_simplex_map
    import ucs_pkg::*;
#(
    parameter int MAX_SPLIT = DEF_MAX_SPLIT,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [23:0]        s_tdata,   // [17:0] cube_value
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata,   // [16:0] sensitivity, [20:17] sub_x, [24:21] sub_y
    output logic               m_tuser,   // [0] status
    output logic               m_tlast,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [SPLIT_W-1:0] cfg_data
);
    localparam int W  = FRAC_BITS + 1;
    localparam int PW = $clog2(MAX_SPLIT);
    localparam int EW = $clog2(MAX_SPLIT + 1);
    localparam int KW = 2 * EW;
    localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_CHK    = 3'd2;
    localparam logic [2:0] S_POW    = 3'd3;
    localparam logic [2:0] S_SMUL   = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;
    localparam logic [2:0] S_EMIT1  = 3'd6;
    localparam logic [2:0] S_EMIT2  = 3'd7;

    logic [2:0]         state_reg, state_next;
    logic [SPLIT_W-1:0] xsp_reg, xsp_next, ysp_reg, ysp_next;
    logic [W-1:0]       range_reg, range_next;
    logic [PW-1:0]      px_reg, px_next, py_reg, py_next;
    logic [KW-1:0]      k_reg, k_next, j_reg, j_next;
    logic [W-1:0]       u_reg, u_next, lo_reg, lo_next, hi_reg, hi_next;
    logic [W-1:0]       mid_reg, mid_next, p_reg, p_next, sens_reg, sens_next;
    logic               has2_reg, has2_next;
    logic [SENS_W-1:0]  r1s_reg, r1s_next, r2s_reg, r2s_next;
    logic [COORD_W-1:0] r1x_reg, r1x_next, r1y_reg, r1y_next;
    logic [COORD_W-1:0] r2x_reg, r2x_next, r2y_reg, r2y_next;
    logic               r1st_reg, r1st_next, r1l_reg, r1l_next;
    logic               ov_reg, ov_next;
    logic [SENS_W-1:0]  os_reg, os_next;
    logic [COORD_W-1:0] ox_reg, ox_next, oy_reg, oy_next;
    logic               ost_reg, ost_next, ol_reg, ol_next;

    logic [EW-1:0]      xs, ys;
    logic [KW-1:0]      total, idx;
    logic signed [CUBE_W-1:0] cube;
    logic               err;
    logic [W-1:0]       cval, rem;
    logic [W:0]         midsum;
    logic               mul_start, mul_done;
    logic [W-1:0]       mul_a, mul_b, mul_res;
    logic               slot_free;

    function automatic logic [EW-1:0] eff_split(input logic [SPLIT_W-1:0] v);
        if (v == '0)
            return EW'(1);
        else if (32'(v) > MAX_SPLIT)
            return EW'(MAX_SPLIT);
        else
            return EW'(v);
    endfunction

    ucs_sermul #(.W(W)) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .result (mul_res)
    );

    assign xs        = eff_split(xsp_reg);
    assign ys        = eff_split(ysp_reg);
    assign total     = KW'(xs) * KW'(ys);
    assign idx       = KW'(py_reg) * KW'(xs) + KW'(px_reg);
    assign cube      = $signed(s_tdata[CUBE_W-1:0]);
    assign err       = cube[CUBE_W-1] || (34'(unsigned'(cube)) > 34'(ONE));
    assign cval      = W'(unsigned'(cube));
    assign rem       = range_reg - sens_reg;
    assign midsum    = {1'b0, lo_reg} + {1'b0, hi_reg} + (W+1)'(1);
    assign slot_free = !ov_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        xsp_next   = xsp_reg;
        ysp_next   = ysp_reg;
        range_next = range_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        u_next     = u_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        p_next     = p_reg;
        sens_next  = sens_reg;
        has2_next  = has2_reg;
        r1s_next   = r1s_reg;
        r1x_next   = r1x_reg;
        r1y_next   = r1y_reg;
        r1st_next  = r1st_reg;
        r1l_next   = r1l_reg;
        r2s_next   = r2s_reg;
        r2x_next   = r2x_reg;
        r2y_next   = r2y_reg;
        ov_next    = ov_reg && !m_tready;
        os_next    = os_reg;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        ost_next   = ost_reg;
        ol_next    = ol_reg;
        mul_start  = 1'b0;
        mul_a      = p_reg;
        mul_b      = mid_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    if (cfg_index == REG_X_SPLIT)
                        xsp_next = cfg_data;
                    else
                        ysp_next = cfg_data;
                    range_next = ONE;
                    px_next    = '0;
                    py_next    = '0;
                end
                else if (s_tvalid)
                begin
                    has2_next  = 1'b0;
                    r1st_next  = 1'b0;
                    r1l_next   = 1'b0;
                    state_next = S_EMIT1;
                    if (err)
                    begin
                        r1s_next   = '0;
                        r1x_next   = COORD_W'(px_reg);
                        r1y_next   = COORD_W'(py_reg);
                        r1st_next  = 1'b1;
                        r1l_next   = 1'b1;
                        range_next = ONE;
                        px_next    = '0;
                        py_next    = '0;
                    end
                    else if (total < KW'(2))
                    begin
                        r1s_next   = SENS_W'(ONE);
                        r1x_next   = '0;
                        r1y_next   = '0;
                        r1l_next   = 1'b1;
                        range_next = ONE;
                        px_next    = '0;
                        py_next    = '0;
                    end
                    else
                    begin
                        if (idx > total - KW'(2))
                        begin
                            range_next = ONE;
                            px_next    = '0;
                            py_next    = '0;
                            k_next     = total - KW'(1);
                        end
                        else
                            k_next = total - KW'(1) - idx;
                        if (cval == ONE)
                        begin
                            sens_next  = (idx > total - KW'(2)) ? ONE : range_reg;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            u_next     = ONE - cval;
                            lo_next    = '0;
                            hi_next    = ONE;
                            state_next = S_SEARCH;
                        end
                    end
                end
            end
            S_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = midsum[W:1];
                    p_next     = ONE;
                    j_next     = '0;
                    state_next = S_CHK;
                end
                else
                begin
                    mul_start  = 1'b1;
                    mul_a      = range_reg;
                    mul_b      = ONE - lo_reg;
                    state_next = S_SMUL;
                end
            end
            S_CHK:
            begin
                if (p_reg <= u_reg)
                begin
                    lo_next    = mid_reg;
                    state_next = S_SEARCH;
                end
                else if (j_reg == k_reg)
                begin
                    hi_next    = mid_reg - W'(1);
                    state_next = S_SEARCH;
                end
                else
                begin
                    mul_start  = 1'b1;
                    j_next     = j_reg + KW'(1);
                    state_next = S_POW;
                end
            end
            S_POW:
            begin
                if (mul_done)
                begin
                    p_next     = mul_res;
                    state_next = S_CHK;
                end
            end
            S_SMUL:
            begin
                if (mul_done)
                begin
                    sens_next  = (mul_res > range_reg) ? range_reg : mul_res;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                r1s_next   = SENS_W'(sens_reg);
                r1x_next   = COORD_W'(px_reg);
                r1y_next   = COORD_W'(py_reg);
                range_next = rem;
                if (k_reg == KW'(1))
                begin
                    has2_next  = 1'b1;
                    r2s_next   = SENS_W'(rem);
                    r2x_next   = COORD_W'(xs - EW'(1));
                    r2y_next   = COORD_W'(ys - EW'(1));
                    range_next = ONE;
                    px_next    = '0;
                    py_next    = '0;
                end
                else if (32'(px_reg) + 1 >= 32'(xs))
                begin
                    px_next = '0;
                    py_next = py_reg + PW'(1);
                end
                else
                    px_next = px_reg + PW'(1);
                state_next = S_EMIT1;
            end
            S_EMIT1:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    os_next    = r1s_reg;
                    ox_next    = r1x_reg;
                    oy_next    = r1y_reg;
                    ost_next   = r1st_reg;
                    ol_next    = r1l_reg;
                    state_next = has2_reg ? S_EMIT2 : S_IDLE;
                end
            end
            S_EMIT2:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    os_next    = r2s_reg;
                    ox_next    = r2x_reg;
                    oy_next    = r2y_reg;
                    ost_next   = 1'b0;
                    ol_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            xsp_reg   <= SPLIT_RESET;
            ysp_reg   <= SPLIT_RESET;
            range_reg <= ONE;
            px_reg    <= '0;
            py_reg    <= '0;
            ov_reg    <= 1'b0;
            has2_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            xsp_reg   <= xsp_next;
            ysp_reg   <= ysp_next;
            range_reg <= range_next;
            px_reg    <= px_next;
            py_reg    <= py_next;
            ov_reg    <= ov_next;
            has2_reg  <= has2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        j_reg    <= j_next;
        u_reg    <= u_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        p_reg    <= p_next;
        sens_reg <= sens_next;
        r1s_reg  <= r1s_next;
        r1x_reg  <= r1x_next;
        r1y_reg  <= r1y_next;
        r1st_reg <= r1st_next;
        r1l_reg  <= r1l_next;
        r2s_reg  <= r2s_next;
        r2x_reg  <= r2x_next;
        r2y_reg  <= r2y_next;
        os_reg   <= os_next;
        ox_reg   <= ox_next;
        oy_reg   <= oy_next;
        ost_reg  <= ost_next;
        ol_reg   <= ol_next;
    end

    assign s_tready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign m_tvalid  = ov_reg;
    assign m_tdata   = {7'd0, oy_reg, ox_reg, os_reg};
    assign m_tuser   = ost_reg;
    assign m_tlast   = ol_reg;
endmodule

/* rtl/ucs_checker.sv */
// Port-level checker for the unit cube to simplex map, bound to the top level.
module ucs_checker
    import ucs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata[SENS_W-1:0] == '0))
        else $error("error item without last or with nonzero sensitivity");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is still in work");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output item changed");
endmodule

bind unit_cube_to_simplex_map ucs_checker u_ucs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
